@@ sv/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character constants and operator tables for the
// infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_MOD   = 8'h25;  // '%'
  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'

  // Stacked operator codes
  typedef logic [2:0] op_code_t;
  localparam op_code_t OPC_OPEN = 3'd0;
  localparam op_code_t OPC_ADD  = 3'd1;
  localparam op_code_t OPC_SUB  = 3'd2;
  localparam op_code_t OPC_MUL  = 3'd3;
  localparam op_code_t OPC_DIV  = 3'd4;
  localparam op_code_t OPC_MOD  = 3'd5;
  localparam op_code_t OPC_POW  = 3'd6;
  localparam op_code_t OPC_NONE = 3'd7;

  // Character classes
  typedef logic [1:0] char_cls_t;
  localparam char_cls_t CLS_OPERAND = 2'd0;
  localparam char_cls_t CLS_OPEN    = 2'd1;
  localparam char_cls_t CLS_CLOSE   = 2'd2;
  localparam char_cls_t CLS_OP      = 2'd3;

  // Datapath operations
  typedef logic [2:0] dp_op_t;
  localparam dp_op_t DP_NOP       = 3'd0;
  localparam dp_op_t DP_PUSH      = 3'd1;
  localparam dp_op_t DP_POP_EMIT  = 3'd2;
  localparam dp_op_t DP_POP_DROP  = 3'd3;
  localparam dp_op_t DP_EMIT_CHAR = 3'd4;
  localparam dp_op_t DP_FINISH    = 3'd5;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } itp_cmd_t;

  typedef struct packed {
    char_cls_t cls;
    logic      cnt_zero;
    logic      top_open;
    logic      pop_ok;
    logic      last;
    logic      out_free;
  } itp_sts_t;

  function automatic op_code_t op_code(input logic [7:0] ch);
    op_code_t c;
    unique case (ch)
      CH_ADD:  c = OPC_ADD;
      CH_SUB:  c = OPC_SUB;
      CH_MUL:  c = OPC_MUL;
      CH_DIV:  c = OPC_DIV;
      CH_MOD:  c = OPC_MOD;
      CH_POW:  c = OPC_POW;
      CH_OPEN: c = OPC_OPEN;
      default: c = OPC_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t c);
    logic [7:0] ch;
    unique case (c)
      OPC_OPEN: ch = CH_OPEN;
      OPC_ADD:  ch = CH_ADD;
      OPC_SUB:  ch = CH_SUB;
      OPC_MUL:  ch = CH_MUL;
      OPC_DIV:  ch = CH_DIV;
      OPC_MOD:  ch = CH_MOD;
      OPC_POW:  ch = CH_POW;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] code_prio(input op_code_t c);
    logic [2:0] p;
    unique case (c)
      OPC_ADD, OPC_SUB: p = 3'd1;
      OPC_MUL, OPC_DIV: p = 3'd2;
      OPC_MOD:          p = 3'd3;
      OPC_POW:          p = 3'd4;
      default:          p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/itp_ctrl.sv @@
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer of the converter: walks one character through its pop, push
// and flush steps and issues one datapath operation per cycle when out_free.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  itp_pkg::itp_sts_t sts,
  output itp_pkg::itp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAIN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_END   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Pick the operation and the next step
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = itp_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAIN;
        end
      end
      S_MAIN: begin
        if (sts.out_free) begin
          unique case (sts.cls)
            itp_pkg::CLS_OPERAND: begin
              cmd.op    = itp_pkg::DP_EMIT_CHAR;
              state_nxt = S_FLUSH;
            end
            itp_pkg::CLS_OPEN: begin
              cmd.op    = itp_pkg::DP_PUSH;
              state_nxt = S_FLUSH;
            end
            itp_pkg::CLS_CLOSE: begin
              priority if (!sts.cnt_zero && !sts.top_open) begin
                cmd.op = itp_pkg::DP_POP_EMIT;
              end else if (!sts.cnt_zero) begin
                cmd.op    = itp_pkg::DP_POP_DROP;
                state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_FLUSH;
              end
            end
            default: begin
              if (!sts.cnt_zero && !sts.top_open && sts.pop_ok) begin
                cmd.op = itp_pkg::DP_POP_EMIT;
              end else begin
                cmd.op    = itp_pkg::DP_PUSH;
                state_nxt = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          if (sts.last && !sts.cnt_zero) begin
            cmd.op = itp_pkg::DP_POP_EMIT;
          end else begin
            state_nxt = S_END;
          end
        end
      end
      default: begin
        if (sts.out_free) begin
          cmd.op    = itp_pkg::DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/itp_dp.sv @@
// ----------------------------------------------------------------------------
// itp_dp
// Datapath of the converter: character latch, operator stack memory with a
// registered top entry, one-deep pending result and the output register.
// ----------------------------------------------------------------------------
module itp_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  input  itp_pkg::itp_cmd_t cmd,
  output itp_pkg::itp_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_char_valid,
  output logic              out_last,
  output logic              out_overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Item latch
  logic [7:0]           char_r;
  logic                 last_r;
  itp_pkg::op_code_t    code_r;
  itp_pkg::char_cls_t   cls_r;
  logic                 dropped_r;
  logic                 dropped_nxt;

  // Stack
  itp_pkg::op_code_t    mem [STACK_DEPTH];
  itp_pkg::op_code_t    top_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic [CW-1:0]        cnt_m2;
  logic                 full;
  logic                 mem_we;
  logic                 rd_en;

  // Pending result and output register
  logic                 pend_valid_r;
  logic                 pend_valid_nxt;
  logic [7:0]           pend_char_r;
  logic [7:0]           pend_char_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [7:0]           out_char_r;
  logic [7:0]           out_char_nxt;
  logic                 out_cv_r;
  logic                 out_cv_nxt;
  logic                 out_last_r;
  logic                 out_last_nxt;
  logic                 out_ovf_r;
  logic                 out_ovf_nxt;
  logic                 produce;
  logic [7:0]           produce_char;
  logic                 out_free;

  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign cnt_m2   = cnt_r - CW'(2);
  assign out_free = !out_valid_r || out_ready;

  // Status toward the sequencer
  assign sts.cls      = cls_r;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.top_open = (top_r == itp_pkg::OPC_OPEN);
  assign sts.pop_ok   = (itp_pkg::code_prio(code_r) <= itp_pkg::code_prio(top_r));
  assign sts.last     = last_r;
  assign sts.out_free = out_free;

  // Stack pointer, drop flag and memory enables
  always_comb begin
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    if (cmd.load) begin
      dropped_nxt = 1'b0;
    end
    unique case (cmd.op)
      itp_pkg::DP_PUSH: begin
        if (full) begin
          dropped_nxt = 1'b1;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      itp_pkg::DP_POP_EMIT, itp_pkg::DP_POP_DROP: begin
        cnt_nxt = cnt_r - CW'(1);
        rd_en   = (cnt_r > CW'(1));
      end
      default: begin
      end
    endcase
  end

  // Result sequencing: a new result pushes the pending one out
  always_comb begin
    produce      = 1'b0;
    produce_char = char_r;
    unique case (cmd.op)
      itp_pkg::DP_POP_EMIT: begin
        produce      = 1'b1;
        produce_char = itp_pkg::code_char(top_r);
      end
      itp_pkg::DP_EMIT_CHAR: begin
        produce = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_char_nxt  = pend_char_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_cv_nxt     = out_cv_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    if (produce) begin
      pend_valid_nxt = 1'b1;
      pend_char_nxt  = produce_char;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = pend_char_r;
        out_cv_nxt    = 1'b1;
        out_last_nxt  = 1'b0;
        out_ovf_nxt   = dropped_r;
      end
    end else if (cmd.op == itp_pkg::DP_FINISH) begin
      pend_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = pend_char_r;
        out_cv_nxt    = 1'b1;
        out_last_nxt  = last_r;
        out_ovf_nxt   = dropped_r;
      end else if (last_r || dropped_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = 8'h00;
        out_cv_nxt    = 1'b0;
        out_last_nxt  = last_r;
        out_ovf_nxt   = dropped_r;
      end
    end
  end

  // Stack memory with registered top read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= code_r;
    end
    if (mem_we) begin
      top_r <= code_r;
    end else if (rd_en) begin
      top_r <= mem[cnt_m2[AW-1:0]];
    end
  end

  // Latch the accepted character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char;
      last_r <= in_last;
      code_r <= itp_pkg::op_code(in_char);
      priority if (in_char == itp_pkg::CH_OPEN) begin
        cls_r <= itp_pkg::CLS_OPEN;
      end else if (in_char == itp_pkg::CH_CLOSE) begin
        cls_r <= itp_pkg::CLS_CLOSE;
      end else if (itp_pkg::op_code(in_char) == itp_pkg::OPC_NONE) begin
        cls_r <= itp_pkg::CLS_OPERAND;
      end else begin
        cls_r <= itp_pkg::CLS_OP;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      dropped_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      dropped_r    <= dropped_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_char_r <= pend_char_nxt;
    out_char_r  <= out_char_nxt;
    out_cv_r    <= out_cv_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

@@ sv/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from infix to postfix, one character per transfer.
// ----------------------------------------------------------------------------
// One character is taken at a time and the block works on it until its last
// result has entered the output register. The character is loaded, the
// operators it releases are popped one per cycle while the output register
// is free, then it is emitted or pushed, or a ')' drops its '(', and on the
// final character every operator left is flushed. Results leave through an
// output register, each item's results held back by one step so that the
// final one can carry out_last. A push onto a full stack is dropped and every
// result of that character shows out_overflow; an item that would give no
// result then gives a marker with out_char_valid low, as does a final
// character that releases nothing.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_last,
  output logic       out_overflow
);

  itp_pkg::itp_cmd_t cmd;
  itp_pkg::itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char        (in_char),
    .in_last        (in_last),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

endmodule

@@ sv/itp_checker.sv @@
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_char_valid,
  input logic       out_last,
  input logic       out_overflow
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_char_valid) && $stable(out_last) && $stable(out_overflow))
    else $error("stalled result changed");

  // A marker carries no character and marks either the end or a drop
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char == 8'h00 && (out_last || out_overflow))
    else $error("malformed marker result");

  // Work on one character at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second character taken while busy");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char       (out_char),
  .out_char_valid (out_char_valid),
  .out_last       (out_last),
  .out_overflow   (out_overflow)
);

@@ tb/tb_infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the shunting-yard infix-to-postfix converter.
// A short directed table covers the byte extremes, every operator, an
// unmatched ')', an empty final item and a push onto a full stack. Random
// expressions follow, mostly well formed, some nested past the stack depth,
// with stray bytes mixed in. Every accepted character runs through a local
// operator-stack model. Each transfer on the result side is compared field
// by field with the oldest predicted postfix character.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

  localparam int STACK_DEPTH = 16;
  localparam int RAND_ITEMS  = 340;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYC    = 40;
  localparam int DIR_ROWS    = 26;
  localparam int HOLD_AT     = DIR_ROWS + 40;

  // One postfix result and one input character with an optional typed result
  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       last;
    logic       ovf;
  } postfix_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       chk;
    postfix_t   res;
  } stim_t;

  localparam postfix_t NO_RES = '0;

  // Operator character and precedence, indexed by stacked code
  localparam logic [7:0] OP_CHAR [8] = '{itp_pkg::CH_OPEN, itp_pkg::CH_ADD,
                                         itp_pkg::CH_SUB, itp_pkg::CH_MUL,
                                         itp_pkg::CH_DIV, itp_pkg::CH_MOD,
                                         itp_pkg::CH_POW, 8'h00};
  localparam int OP_RANK [8] = '{0, 1, 1, 2, 2, 3, 4, 0};

  // Directed rows: typed result only where one result is obvious
  localparam stim_t DIRECTED [DIR_ROWS] = '{
    '{8'h00,             1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF,             1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{itp_pkg::CH_CLOSE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{"a",               1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_MUL,   1'b0, 1'b0, NO_RES},
    '{"b",               1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_DIV,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_CLOSE, 1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_ADD,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_SUB,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_MUL,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_DIV,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_MOD,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_POW,   1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_OPEN,  1'b0, 1'b0, NO_RES},
    '{itp_pkg::CH_ADD,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{itp_pkg::CH_CLOSE, 1'b1, 1'b0, NO_RES}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_last;
  logic       out_overflow;

  stim_t             stim_q [$];
  postfix_t          postfix_q [$];
  postfix_t          step_res [$];
  itp_pkg::op_code_t op_stk [STACK_DEPTH];
  int                op_cnt = 0;
  int                n_acc = 0;
  int                err_cnt = 0;
  int                snd_idle = 15;
  int                rcv_stall = 60;
  int                stall_cyc = 0;
  postfix_t          want;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  always #5 clk = ~clk;

  // Pop the top operator into the current step's results
  function automatic void pop_op();
    step_res.insert(step_res.size(),
                    postfix_t'{OP_CHAR[op_stk[op_cnt-1]], 1'b1, 1'b0, 1'b0});
    op_cnt--;
  endfunction

  // Push a code; report a drop when the stack is full
  function automatic logic push_op(input itp_pkg::op_code_t code);
    if (op_cnt >= STACK_DEPTH) begin
      return 1'b1;
    end
    op_stk[op_cnt] = code;
    op_cnt++;
    return 1'b0;
  endfunction

  // Shunting-yard step for one character; results land in step_res
  function automatic void shunt_char(input logic [7:0] ch, input logic last);
    itp_pkg::op_code_t code;
    logic              dropped;
    int                k;
    code = itp_pkg::OPC_NONE;
    dropped = 1'b0;
    step_res.delete();
    for (k = itp_pkg::OPC_ADD; k <= itp_pkg::OPC_POW; k++) begin
      if (OP_CHAR[k] == ch) code = itp_pkg::op_code_t'(k);
    end
    if (ch == itp_pkg::CH_OPEN) begin
      dropped = push_op(itp_pkg::OPC_OPEN);
    end else if (ch == itp_pkg::CH_CLOSE) begin
      while (op_cnt > 0 && op_stk[op_cnt-1] != itp_pkg::OPC_OPEN) pop_op();
      if (op_cnt > 0) op_cnt--;
    end else if (code == itp_pkg::OPC_NONE) begin
      step_res.insert(step_res.size(), postfix_t'{ch, 1'b1, 1'b0, 1'b0});
    end else begin
      while (op_cnt > 0 && op_stk[op_cnt-1] != itp_pkg::OPC_OPEN &&
             OP_RANK[code] <= OP_RANK[op_stk[op_cnt-1]]) pop_op();
      dropped = push_op(code);
    end
    // Flush after the final character
    if (last) begin
      while (op_cnt > 0) pop_op();
    end
    if (step_res.size() == 0 && (last || dropped)) begin
      step_res.insert(step_res.size(), postfix_t'{8'h00, 1'b0, 1'b0, 1'b0});
    end
    foreach (step_res[j]) step_res[j].ovf = dropped;
    if (last) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    if ($urandom_range(99) < 80) begin
      return 8'h61 + 8'($urandom_range(25));
    end
    do c = 8'($urandom_range(255));
    while (c inside {itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE, itp_pkg::CH_ADD,
                     itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV,
                     itp_pkg::CH_MOD, itp_pkg::CH_POW});
    return c;
  endfunction

  function automatic void add_char(input logic [7:0] ch, input logic last);
    stim_q.insert(stim_q.size(), stim_t'{ch, last, 1'b0, NO_RES});
  endfunction

  // Append one random expression; some nest deep enough to overflow the stack
  function automatic void add_expr();
    int  depth;
    int  terms;
    int  open_pct;
    int  t;
    logic deep;
    deep = ($urandom_range(19) == 0);
    open_pct = deep ? 70 : 20;
    terms = deep ? $urandom_range(10, 24) : $urandom_range(1, 8);
    depth = 0;
    for (t = 0; t < terms; t++) begin
      while (depth < 24 && $urandom_range(99) < open_pct) begin
        add_char(itp_pkg::CH_OPEN, 1'b0);
        depth++;
      end
      add_char(rand_operand(), 1'b0);
      while (depth > 0 && $urandom_range(99) < 30) begin
        add_char(itp_pkg::CH_CLOSE, 1'b0);
        depth--;
      end
      if (t < terms - 1) begin
        add_char(OP_CHAR[$urandom_range(itp_pkg::OPC_ADD, itp_pkg::OPC_POW)], 1'b0);
      end
    end
    // Close most open brackets; leave some for the flush
    while (depth > 0 && $urandom_range(99) < 70) begin
      add_char(itp_pkg::CH_CLOSE, 1'b0);
      depth--;
    end
    stim_q[stim_q.size()-1].last = 1'b1;
  endfunction

  function automatic void chk_field(input string what, input int unsigned exp_v,
                                    input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shunt_char(in_char, in_last);
        if (stim_q[n_acc].chk) begin
          postfix_q.insert(postfix_q.size(), stim_q[n_acc].res);
        end else begin
          foreach (step_res[k]) postfix_q.insert(postfix_q.size(), step_res[k]);
        end
        n_acc++;
      end
      if (out_valid && out_ready) begin
        if (postfix_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got char %0h valid %0b",
                   $time, out_char, out_char_valid);
          err_cnt++;
        end else begin
          want = postfix_q.pop_front();
          chk_field("out_char", want.ch, out_char);
          chk_field("out_char_valid", want.cv, out_char_valid);
          chk_field("out_last", want.last, out_last);
          chk_field("out_overflow", want.ovf, out_overflow);
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cyc <= 0;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
    if (stall_cyc >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && n_acc >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  // Input side: reset, build stimulus, then send it in three idling phases
  initial begin
    int   i;
    int   n3;
    logic drain;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char <= 8'h00;
    in_last <= 1'b0;
    foreach (DIRECTED[r]) stim_q.insert(stim_q.size(), DIRECTED[r]);
    while (stim_q.size() < DIR_ROWS + RAND_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        add_char(8'($urandom_range(255)), ($urandom_range(3) == 0));
      end else begin
        add_expr();
      end
    end
    n3 = stim_q.size() / 3;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < stim_q.size(); i++) begin
      drain = (i == n3 || i == 2 * n3);
      if (i == n3) begin
        snd_idle = 60;
        rcv_stall = 15;
      end else if (i == 2 * n3) begin
        snd_idle = 0;
        rcv_stall = 0;
      end
      // Idle, or at a phase change hold off until every result is in
      if (drain || $urandom_range(99) < snd_idle) begin
        in_valid <= 1'b0;
        do @(posedge clk);
        while (drain ? postfix_q.size() != 0 : $urandom_range(99) < snd_idle);
      end
      in_valid <= 1'b1;
      in_char <= stim_q[i].ch;
      in_last <= stim_q[i].last;
      do @(posedge clk);
      while (!in_ready);
    end
    in_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/itp_pkg.sv
sv/itp_ctrl.sv
sv/itp_dp.sv
sv/infix_to_postfix_converter.sv
sv/itp_checker.sv
tb/tb_infix_to_postfix_converter.sv
